>>> rtl/core/sbt_pkg.sv
// Shared types, codes and character classes for the source byte tokenizer.
// Used by sbt_step, sbt_out_queue and source_byte_tokenizer.
package sbt_pkg;

    localparam int POS_W = 32;
    localparam int LEN_W = 16;
    localparam int MAX_RES = 3;
    localparam int CAND_N = 4;

    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_NUM  = 3'd1;
    localparam logic [2:0] MODE_ID   = 3'd2;
    localparam logic [2:0] MODE_HELD = 3'd3;
    localparam logic [2:0] MODE_ERR  = 3'd4;

    localparam logic [2:0] KIND_NUM   = 3'd0;
    localparam logic [2:0] KIND_ID    = 3'd1;
    localparam logic [2:0] KIND_PUNCT = 3'd2;
    localparam logic [2:0] KIND_ERR   = 3'd3;
    localparam logic [2:0] KIND_END   = 3'd4;

    localparam logic [4:0] PUNCT_EQ_EQ = 5'd0;
    localparam logic [4:0] PUNCT_NE    = 5'd1;
    localparam logic [4:0] PUNCT_LE    = 5'd2;
    localparam logic [4:0] PUNCT_GE    = 5'd3;
    localparam logic [4:0] PUNCT_SHL   = 5'd4;
    localparam logic [4:0] PUNCT_SHR   = 5'd5;
    localparam logic [4:0] PUNCT_LT    = 5'd6;
    localparam logic [4:0] PUNCT_GT    = 5'd7;
    localparam logic [4:0] PUNCT_NONE  = 5'd0;

    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_source;
    } t_in;

    typedef struct packed {
        logic [2:0]       token_kind;
        logic [4:0]       punct_code;
        logic [POS_W-1:0] token_start;
        logic [LEN_W-1:0] token_length;
        logic             last_of_run;
    } t_out;

    typedef struct packed {
        logic [2:0]       mode;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] pstart;
        logic [LEN_W-1:0] plen;
        logic [7:0]       held;
    } t_scan_state;

    typedef struct packed {
        t_out [MAX_RES-1:0] slot;
        logic [1:0]         count;
    } t_res_set;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
    endfunction

    function automatic logic is_ident_tail(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == 8'h5f);
    endfunction

    function automatic logic is_held_char(input logic [7:0] c);
        return (c == 8'h3c) || (c == 8'h3e) || (c == 8'h3d) || (c == 8'h21);
    endfunction

    // Two-character punctuators: held first character h, current byte c.
    function automatic logic is_pair(input logic [7:0] h, input logic [7:0] c);
        return (c == 8'h3d && (h == 8'h3d || h == 8'h21 || h == 8'h3c || h == 8'h3e))
            || (h == 8'h3c && c == 8'h3c) || (h == 8'h3e && c == 8'h3e);
    endfunction

    function automatic logic [4:0] pair_code(input logic [7:0] h, input logic [7:0] c);
        logic [4:0] code;
        code = PUNCT_NONE;
        if (c == 8'h3d) begin
            unique case (h)
                8'h3d:   code = PUNCT_EQ_EQ;
                8'h21:   code = PUNCT_NE;
                8'h3c:   code = PUNCT_LE;
                8'h3e:   code = PUNCT_GE;
                default: code = PUNCT_NONE;
            endcase
        end else if (h == 8'h3c) begin
            code = PUNCT_SHL;
        end else begin
            code = PUNCT_SHR;
        end
        return code;
    endfunction

    // Single-character punctuators; bit 5 of the result flags a match.
    function automatic logic [5:0] single_lookup(input logic [7:0] c);
        logic [5:0] r;
        unique case (c)
            8'h2b:   r = {1'b1, 5'd8};
            8'h2d:   r = {1'b1, 5'd9};
            8'h2a:   r = {1'b1, 5'd10};
            8'h2f:   r = {1'b1, 5'd11};
            8'h28:   r = {1'b1, 5'd12};
            8'h29:   r = {1'b1, 5'd13};
            8'h7b:   r = {1'b1, 5'd14};
            8'h7d:   r = {1'b1, 5'd15};
            8'h5b:   r = {1'b1, 5'd16};
            8'h5d:   r = {1'b1, 5'd17};
            8'h2c:   r = {1'b1, 5'd18};
            8'h2e:   r = {1'b1, 5'd19};
            8'h3b:   r = {1'b1, 5'd20};
            8'h3a:   r = {1'b1, 5'd21};
            default: r = {1'b0, PUNCT_NONE};
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/source_byte_tokenizer.sv
// Streaming tokenizer top level: input register, scan state and result bank.
// Depends on sbt_pkg, sbt_step and sbt_out_queue.
//
// Usage: source bytes enter on the i_in_* valid/ready channel, one byte per
// transfer, with end_of_source set on the final byte of a source. Tokens
// leave on the o_out_* channel; last_of_run marks the final result that a
// byte caused. A byte may cause zero to three results.
// A byte passes through the input register and then the result bank, which
// registers its results; the byte waits in the input register until the bank is free.
// Throughput: one byte per cycle while each byte gives at most one result
// and the receiver is ready; a byte with more results holds the scanner until
// the single output port has drained the result bank.
// Reset (synchronous, active low) clears position and scan state and empties
// both the input register and the result bank. The end marker also returns
// the scan state to reset, so the next byte starts a new source at 0.
// When the receiver stalls, results wait in the bank, the scanner holds the
// next byte in its input register, and o_in_ready drops once that is full.
module source_byte_tokenizer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  sbt_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output sbt_pkg::t_out o_out_data
);
    import sbt_pkg::*;

    logic        r_in_valid;
    t_in         r_in;
    t_scan_state r_state;
    t_scan_state n_state;
    t_res_set    step_res;
    logic        q_free;
    logic        step_fire;

    assign step_fire  = r_in_valid && q_free;
    assign o_in_ready = !r_in_valid || step_fire;

    sbt_step u_step (
        .i_item  (r_in),
        .i_state (r_state),
        .o_state (n_state),
        .o_res   (step_res)
    );

    sbt_out_queue u_out_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (step_fire),
        .i_res       (step_res),
        .o_free      (q_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode   <= MODE_IDLE;
            r_state.pos    <= '0;
            r_state.pstart <= '0;
            r_state.plen   <= '0;
            r_state.held   <= '0;
        end else if (step_fire) begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/core/sbt_step.sv
// Per-byte scanner logic: classifies one byte against the scan state and
// produces the next state and up to three results. Depends on sbt_pkg.
module sbt_step (
    input  sbt_pkg::t_in         i_item,
    input  sbt_pkg::t_scan_state i_state,
    output sbt_pkg::t_scan_state o_state,
    output sbt_pkg::t_res_set    o_res
);
    import sbt_pkg::*;

    function automatic t_out make_res(input logic [2:0] kind, input logic [4:0] code,
                                      input logic [POS_W-1:0] start,
                                      input logic [LEN_W-1:0] len);
        t_out r;
        r.token_kind   = kind;
        r.punct_code   = code;
        r.token_start  = start;
        r.token_length = len;
        r.last_of_run  = 1'b0;
        return r;
    endfunction

    // A held character that did not pair: < and > stand alone, = and ! are errors.
    function automatic t_out held_res(input logic [7:0] h, input logic [POS_W-1:0] start);
        t_out r;
        if (h == 8'h3c) begin
            r = make_res(KIND_PUNCT, PUNCT_LT, start, LEN_W'(1));
        end else if (h == 8'h3e) begin
            r = make_res(KIND_PUNCT, PUNCT_GT, start, LEN_W'(1));
        end else begin
            r = make_res(KIND_ERR, PUNCT_NONE, start, LEN_W'(1));
        end
        return r;
    endfunction

    logic [7:0]        c;
    logic              consumed;
    logic              cont;
    logic [5:0]        single;
    logic [POS_W-1:0]  pos_inc;
    t_out              cand [CAND_N];
    logic [CAND_N-1:0] cand_v;
    t_scan_state       nxt;
    logic [1:0]        idx;
    t_res_set          res;

    assign c       = i_item.char_byte;
    assign single  = single_lookup(c);
    assign pos_inc = i_state.pos + POS_W'(1);

    always_comb begin
        nxt      = i_state;
        consumed = 1'b0;
        cont     = 1'b0;
        cand_v   = '0;
        for (int i = 0; i < CAND_N; i++) begin
            cand[i] = '0;
        end

        // Continue or close whatever was open before this byte.
        unique case (i_state.mode)
            MODE_NUM, MODE_ID: begin
                cont = (i_state.mode == MODE_NUM) ? is_digit(c) : is_ident_tail(c);
                if (cont) begin
                    if (i_state.plen != LEN_MAX) begin
                        nxt.plen = i_state.plen + LEN_W'(1);
                    end
                    consumed = 1'b1;
                end else begin
                    cand_v[0] = 1'b1;
                    cand[0]   = make_res((i_state.mode == MODE_NUM) ? KIND_NUM : KIND_ID,
                                         PUNCT_NONE, i_state.pstart, i_state.plen);
                    nxt.mode  = MODE_IDLE;
                end
            end
            MODE_HELD: begin
                cand_v[0] = 1'b1;
                if (is_pair(i_state.held, c)) begin
                    cand[0]  = make_res(KIND_PUNCT, pair_code(i_state.held, c),
                                        i_state.pstart, LEN_W'(2));
                    nxt.mode = MODE_IDLE;
                    consumed = 1'b1;
                end else if (i_state.held == 8'h3c || i_state.held == 8'h3e) begin
                    cand[0]  = held_res(i_state.held, i_state.pstart);
                    nxt.mode = MODE_IDLE;
                end else begin
                    cand[0]  = held_res(i_state.held, i_state.pstart);
                    nxt.mode = MODE_ERR;
                    consumed = 1'b1;
                end
            end
            MODE_ERR: begin
                consumed = 1'b1;
            end
            default: begin
                nxt.mode = MODE_IDLE;
            end
        endcase

        // The byte was not taken by the open token, so it starts something new.
        if (!consumed) begin
            if (is_space(c)) begin
                nxt.mode = MODE_IDLE;
            end else begin
                nxt.pstart = i_state.pos;
                nxt.plen   = LEN_W'(1);
                if (is_digit(c)) begin
                    nxt.mode = MODE_NUM;
                end else if (is_ident_tail(c)) begin
                    nxt.mode = MODE_ID;
                end else if (is_held_char(c)) begin
                    nxt.mode = MODE_HELD;
                    nxt.held = c;
                end else if (single[5]) begin
                    cand_v[1] = 1'b1;
                    cand[1]   = make_res(KIND_PUNCT, single[4:0], i_state.pos, LEN_W'(1));
                    nxt.mode  = MODE_IDLE;
                end else begin
                    cand_v[1] = 1'b1;
                    cand[1]   = make_res(KIND_ERR, PUNCT_NONE, i_state.pos, LEN_W'(1));
                    nxt.mode  = MODE_ERR;
                end
            end
        end

        if (i_item.end_of_source) begin
            if (nxt.mode == MODE_NUM || nxt.mode == MODE_ID) begin
                cand_v[2] = 1'b1;
                cand[2]   = make_res((nxt.mode == MODE_NUM) ? KIND_NUM : KIND_ID,
                                     PUNCT_NONE, nxt.pstart, nxt.plen);
            end else if (nxt.mode == MODE_HELD) begin
                cand_v[2] = 1'b1;
                cand[2]   = held_res(nxt.held, nxt.pstart);
            end
            cand_v[3] = 1'b1;
            cand[3]   = make_res(KIND_END, PUNCT_NONE, pos_inc, '0);
            nxt.mode   = MODE_IDLE;
            nxt.pos    = '0;
            nxt.pstart = '0;
            nxt.plen   = '0;
            nxt.held   = '0;
        end else begin
            nxt.pos = pos_inc;
        end
    end

    // Pack the candidates in order; at most three are ever present together.
    always_comb begin
        res = '0;
        idx = 2'd0;
        for (int i = 0; i < CAND_N; i++) begin
            if (cand_v[i] && idx != 2'd3) begin
                res.slot[idx] = cand[i];
                idx = idx + 2'd1;
            end
        end
        res.count = idx;
        if (idx != 2'd0) begin
            res.slot[idx - 2'd1].last_of_run = 1'b1;
        end
    end

    assign o_state = nxt;
    assign o_res   = res;

endmodule

>>> rtl/core/sbt_out_queue.sv
// Result register bank: holds the results of one byte and hands them out
// one transfer per cycle while the receiver is ready. Depends on sbt_pkg.
module sbt_out_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  sbt_pkg::t_res_set  i_res,
    output logic               o_free,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sbt_pkg::t_out      o_out_data
);
    import sbt_pkg::*;

    t_out [MAX_RES-1:0] r_slot;
    logic [1:0]         r_cnt;
    logic [1:0]         r_head;
    logic               pop;

    assign o_out_valid = (r_head != r_cnt);
    assign pop         = o_out_valid && i_out_ready;
    // The bank can take a new set when it is empty or its last result leaves this cycle.
    assign o_free      = !o_out_valid || (pop && (r_head + 2'd1 == r_cnt));

    always_comb begin
        unique case (r_head)
            2'd0:    o_out_data = r_slot[0];
            2'd1:    o_out_data = r_slot[1];
            2'd2:    o_out_data = r_slot[2];
            default: o_out_data = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_head <= 2'd0;
        end else if (i_load) begin
            r_cnt  <= i_res.count;
            r_head <= 2'd0;
        end else if (pop) begin
            r_head <= r_head + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot <= i_res.slot;
        end
    end

endmodule

>>> test/tb_source_byte_tokenizer.sv
// Self-checking testbench for source_byte_tokenizer: byte streams in, tokens out.
// Holds its own scanner model of the lexer and depends on sbt_pkg and the RTL.
`timescale 1ns / 1ps

module tb_source_byte_tokenizer;
    import sbt_pkg::*;

    localparam int HOLD_CYCLES   = 250;
    localparam int STALL_LIMIT   = 3000;
    localparam int RANDOM_BYTES  = 115;

    localparam logic [7:0] CH_EQ    = "=";
    localparam logic [7:0] CH_BANG  = "!";
    localparam logic [7:0] CH_LT    = "<";
    localparam logic [7:0] CH_GT    = ">";
    localparam logic [7:0] CH_UNDER = "_";
    localparam logic [4:0] PUNCT_SINGLE_BASE = 5'd8;
    localparam logic [14*8-1:0] SINGLE_CHARS = "+-*/(){}[],.;:";
    localparam logic [12*8-1:0] PAIR_CHARS   = "==!=<=>=<<>>";

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    t_in  in_data = '0;
    logic out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;

    source_byte_tokenizer dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    always #6 i_clk = ~i_clk;

    // Scanner model state.
    logic [2:0]       scan_mode = MODE_IDLE;
    logic [POS_W-1:0] scan_pos = '0;
    logic [POS_W-1:0] tok_start = '0;
    logic [LEN_W-1:0] tok_len = '0;
    logic [7:0]       held_char = '0;

    t_out       byte_tokens[$];
    t_out       expected_tokens[$];
    t_in        byte_queue[$];
    logic [7:0] source_text[$];

    int mismatches = 0;
    int tokens_seen = 0;
    int burst_left = 0;
    int gap_left = 0;
    bit sender_gaps = 1'b1;
    int ready_style = 1;
    logic [15:0] ready_pattern = 16'hffff;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    logic [31:0] rx_cycle = '0;
    int idle_cycles = 0;

    function automatic bit is_num_char(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_name_char(input logic [7:0] c);
        return is_letter(c) || is_num_char(c) || c == CH_UNDER;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == " " || (c >= "\t" && c <= "\r");
    endfunction

    // Bit 5 flags a two-character punctuator formed by held h and current c.
    function automatic logic [5:0] pair_match(input logic [7:0] h, input logic [7:0] c);
        if (c == CH_EQ) begin
            if (h == CH_EQ) return {1'b1, PUNCT_EQ_EQ};
            if (h == CH_BANG) return {1'b1, PUNCT_NE};
            if (h == CH_LT) return {1'b1, PUNCT_LE};
            if (h == CH_GT) return {1'b1, PUNCT_GE};
        end
        if (h == CH_LT && c == CH_LT) return {1'b1, PUNCT_SHL};
        if (h == CH_GT && c == CH_GT) return {1'b1, PUNCT_SHR};
        return {1'b0, PUNCT_NONE};
    endfunction

    function automatic logic [5:0] single_match(input logic [7:0] c);
        for (int i = 0; i < 14; i++) begin
            if (SINGLE_CHARS[(13 - i) * 8 +: 8] == c) return {1'b1, PUNCT_SINGLE_BASE + 5'(i)};
        end
        return {1'b0, PUNCT_NONE};
    endfunction

    task automatic emit(input logic [2:0] kind, input logic [4:0] code,
                        input logic [POS_W-1:0] start, input logic [LEN_W-1:0] len);
        t_out r;
        r.token_kind = kind;
        r.punct_code = code;
        r.token_start = start;
        r.token_length = len;
        r.last_of_run = 1'b0;
        byte_tokens.push_back(r);
    endtask

    task automatic emit_pending();
        case (scan_mode)
            MODE_NUM: emit(KIND_NUM, PUNCT_NONE, tok_start, tok_len);
            MODE_ID: emit(KIND_ID, PUNCT_NONE, tok_start, tok_len);
            MODE_HELD: begin
                if (held_char == CH_LT) emit(KIND_PUNCT, PUNCT_LT, tok_start, LEN_W'(1));
                else if (held_char == CH_GT) emit(KIND_PUNCT, PUNCT_GT, tok_start, LEN_W'(1));
                else emit(KIND_ERR, PUNCT_NONE, tok_start, LEN_W'(1));
            end
            default: ;
        endcase
    endtask

    // Advances the model by one accepted byte and queues the tokens it yields.
    task automatic scan_byte(input t_in item);
        logic [7:0]       c;
        logic [POS_W-1:0] p;
        logic [5:0]       pm;
        bit               consumed;
        t_out             r;
        c = item.char_byte;
        p = scan_pos;
        consumed = 1'b0;
        byte_tokens.delete();
        case (scan_mode)
            MODE_NUM, MODE_ID: begin
                if ((scan_mode == MODE_NUM && is_num_char(c)) ||
                    (scan_mode == MODE_ID && is_name_char(c))) begin
                    if (tok_len != LEN_MAX) tok_len = tok_len + 1'b1;
                    consumed = 1'b1;
                end else begin
                    emit_pending();
                    scan_mode = MODE_IDLE;
                end
            end
            MODE_HELD: begin
                pm = pair_match(held_char, c);
                if (pm[5]) begin
                    emit(KIND_PUNCT, pm[4:0], tok_start, LEN_W'(2));
                    scan_mode = MODE_IDLE;
                    consumed = 1'b1;
                end else if (held_char == CH_LT || held_char == CH_GT) begin
                    emit_pending();
                    scan_mode = MODE_IDLE;
                end else begin
                    // A lone = or ! is an error, and it swallows this byte too.
                    emit_pending();
                    scan_mode = MODE_ERR;
                    consumed = 1'b1;
                end
            end
            MODE_ERR: consumed = 1'b1;
            default: scan_mode = MODE_IDLE;
        endcase

        if (!consumed) begin
            if (is_blank(c)) begin
                scan_mode = MODE_IDLE;
            end else begin
                tok_start = p;
                tok_len = LEN_W'(1);
                pm = single_match(c);
                if (is_num_char(c)) begin
                    scan_mode = MODE_NUM;
                end else if (is_letter(c) || c == CH_UNDER) begin
                    scan_mode = MODE_ID;
                end else if (c == CH_LT || c == CH_GT || c == CH_EQ || c == CH_BANG) begin
                    scan_mode = MODE_HELD;
                    held_char = c;
                end else if (pm[5]) begin
                    emit(KIND_PUNCT, pm[4:0], p, LEN_W'(1));
                    scan_mode = MODE_IDLE;
                end else begin
                    emit(KIND_ERR, PUNCT_NONE, p, LEN_W'(1));
                    scan_mode = MODE_ERR;
                end
            end
        end

        if (item.end_of_source) begin
            emit_pending();
            emit(KIND_END, PUNCT_NONE, p + 1'b1, '0);
            scan_mode = MODE_IDLE;
            scan_pos = '0;
            tok_start = '0;
            tok_len = '0;
            held_char = '0;
        end else begin
            scan_pos = p + 1'b1;
        end

        if (byte_tokens.size() != 0) begin
            r = byte_tokens.pop_back();
            r.last_of_run = 1'b1;
            byte_tokens.push_back(r);
        end
        foreach (byte_tokens[i]) expected_tokens.push_back(byte_tokens[i]);
    endtask

    task automatic report(input string msg);
        mismatches++;
        $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    task automatic check_token(input t_out got);
        t_out want;
        if (expected_tokens.size() == 0) begin
            report($sformatf("token %0d arrived with nothing expected (kind %0d start %0d)",
                             tokens_seen, got.token_kind, got.token_start));
        end else begin
            want = expected_tokens.pop_front();
            if (got.token_kind !== want.token_kind)
                report($sformatf("token %0d: kind %0d, expected %0d",
                                 tokens_seen, got.token_kind, want.token_kind));
            if (got.punct_code !== want.punct_code)
                report($sformatf("token %0d: punct_code %0d, expected %0d",
                                 tokens_seen, got.punct_code, want.punct_code));
            if (got.token_start !== want.token_start)
                report($sformatf("token %0d: start %0d, expected %0d",
                                 tokens_seen, got.token_start, want.token_start));
            if (got.token_length !== want.token_length)
                report($sformatf("token %0d: length %0d, expected %0d",
                                 tokens_seen, got.token_length, want.token_length));
            if (got.last_of_run !== want.last_of_run)
                report($sformatf("token %0d: last_of_run %0b, expected %0b",
                                 tokens_seen, got.last_of_run, want.last_of_run));
        end
        tokens_seen++;
    endtask

    // Input side: predicts each byte on transfer, then offers the next in bursts.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_data <= '0;
        end else begin
            if (in_valid && o_in_ready) scan_byte(in_data);
            if (!in_valid || o_in_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (byte_queue.size() != 0) begin
                    in_valid <= 1'b1;
                    in_data <= byte_queue.pop_front();
                    if (burst_left != 0) begin
                        burst_left--;
                    end else if (sender_gaps) begin
                        burst_left = $urandom_range(0, 20);
                        gap_left = $urandom_range(1, 6);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output side: checks each transfer; stalls on a reshuffled pattern or a long hold.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) check_token(o_out_data);
            rx_cycle = rx_cycle + 32'd1;
            if (rx_cycle[5:0] == 6'd0) ready_pattern = 16'($urandom) | 16'h8001;
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (ready_style == 0) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= ready_pattern[rx_cycle[3:0]];
            end
        end
    end

    always @(posedge i_clk) begin
        if (rst_n) begin
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) source_text.push_back(s[i]);
    endtask

    // Moves the collected source into the send queue, flagging its last byte.
    task automatic commit_source();
        t_in item;
        foreach (source_text[i]) begin
            item.char_byte = source_text[i];
            item.end_of_source = (i == source_text.size() - 1);
            byte_queue.push_back(item);
        end
        source_text.delete();
    endtask

    function automatic logic [7:0] pick_name_char();
        int r;
        r = $urandom_range(0, 62);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        if (r < 62) return 8'("0" + r - 52);
        return CH_UNDER;
    endfunction

    // Mostly well-formed token sequences; some sources are pure noise.
    task automatic make_random_source();
        int kind;
        int r;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 8)) source_text.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(1, 10)) begin
                kind = $urandom_range(0, 99);
                if (kind < 24) begin
                    repeat ($urandom_range(1, 5))
                        source_text.push_back(8'("0" + $urandom_range(0, 9)));
                end else if (kind < 48) begin
                    r = $urandom_range(0, 52);
                    if (r == 52) source_text.push_back(CH_UNDER);
                    else if (r < 26) source_text.push_back(8'("a" + r));
                    else source_text.push_back(8'("A" + r - 26));
                    repeat ($urandom_range(0, 6)) source_text.push_back(pick_name_char());
                end else if (kind < 74) begin
                    r = $urandom_range(0, 21);
                    if (r < 6) begin
                        source_text.push_back(PAIR_CHARS[(11 - 2 * r) * 8 +: 8]);
                        source_text.push_back(PAIR_CHARS[(10 - 2 * r) * 8 +: 8]);
                    end else if (r == 6) begin
                        source_text.push_back(CH_LT);
                    end else if (r == 7) begin
                        source_text.push_back(CH_GT);
                    end else begin
                        source_text.push_back(SINGLE_CHARS[(21 - r) * 8 +: 8]);
                    end
                end else if (kind < 90) begin
                    repeat ($urandom_range(1, 3)) begin
                        r = $urandom_range(0, 5);
                        source_text.push_back(r == 5 ? 8'(" ") : 8'("\t" + r));
                    end
                end else if (kind < 95) begin
                    source_text.push_back($urandom_range(0, 1) ? CH_EQ : CH_BANG);
                end else begin
                    source_text.push_back(8'($urandom_range(0, 255)));
                end
            end
        end
        commit_source();
    endtask

    task automatic wait_drained();
        while (byte_queue.size() != 0 || in_valid || expected_tokens.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;

        // Every punctuator, names, numbers and blanks, then a byte with three results.
        add_text("==!=<=>=<<>><>+-*/(){}[],.;:_Az09\t7\n");
        add_text("1+");
        commit_source();
        // Lone = at the end of a source.
        add_text("=");
        commit_source();
        // Lone ! swallows the next byte; the end byte after an error gives only the marker.
        source_text.push_back(CH_BANG);
        source_text.push_back(8'hff);
        source_text.push_back(8'h80);
        commit_source();
        // A non-ASCII byte is an error on its own.
        source_text.push_back(8'hff);
        commit_source();
        add_text("<");
        commit_source();
        wait_drained();

        hold_requests++;
        while (byte_queue.size() < RANDOM_BYTES) make_random_source();
        wait_drained();

        // Back-to-back transfers with no idling on either side.
        sender_gaps = 1'b0;
        ready_style = 0;
        while (byte_queue.size() < RANDOM_BYTES) make_random_source();
        wait_drained();

        sender_gaps = 1'b1;
        ready_style = 1;
        hold_requests++;
        while (byte_queue.size() < RANDOM_BYTES) make_random_source();
        wait_drained();

        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && expected_tokens.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
